// ----- rtl/slm_pkg.sv -----
// Package for the sorted list merge block: sizes, request codes and state type.
`default_nettype none
package slm_pkg;

  // Elements held per list
  localparam int DEPTH  = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Request codes
  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_MERGE  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/slm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module slm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_list_merge.sv -----
// Top level of the sorted list merge block: list stores, merge sequencer, result port.
//
// Usage: each command is a transfer on start while busy is low. in_req_type
// selects append to list A, append to list B, or merge. An append produces no
// result; appends to a full list are dropped, as is the unused request code.
// Appends may come every cycle. A merge with n stored elements in total raises
// busy from the cycle after the merge transfer; while it is high, out_valid
// strobes the n elements of the ascending sequence in turn (B first on equal
// heads), and out_last marks the final one. A merge of two empty lists
// produces nothing and keeps busy low. The rate of one element per cycle is
// set by the single shared head comparator and the one read port of each
// list RAM, whose next address is prefetched while the current heads are
// compared. After the last element both counts clear, so the next job starts
// empty. Reset (rst_n low, synchronous) clears the counts and returns to idle;
// the list contents are not cleared. The receiver cannot stall: each
// result is valid for exactly one cycle.
`default_nettype none
module sorted_list_merge (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  output logic signed [31:0] out_merged_value,
  output logic             out_last
);

  localparam int AW = slm_pkg::ADDR_W;
  localparam int CW = slm_pkg::CNT_W;
  localparam int DW = slm_pkg::DATA_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(slm_pkg::DEPTH);

  slm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;

  logic          accept;
  logic          we_a, we_b;
  logic [DW-1:0] head_a, head_b;
  logic          a_has, b_has, take_a, done;

  assign accept = start && !busy;
  assign we_a   = accept && (in_req_type == slm_pkg::REQ_LOAD_A) && (cnt_a_r < DEPTH_C);
  assign we_b   = accept && (in_req_type == slm_pkg::REQ_LOAD_B) && (cnt_b_r < DEPTH_C);

  // List stores; read address is the head index for the next cycle
  slm_ram #(.WIDTH(DW), .DEPTH(slm_pkg::DEPTH), .ADDR_W(AW)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (in_value),
    .raddr (ia_nxt[AW-1:0]),
    .rdata (head_a)
  );

  slm_ram #(.WIDTH(DW), .DEPTH(slm_pkg::DEPTH), .ADDR_W(AW)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (in_value),
    .raddr (ib_nxt[AW-1:0]),
    .rdata (head_b)
  );

  // Compare heads in the shared comparator
  assign a_has  = ia_r < cnt_a_r;
  assign b_has  = ib_r < cnt_b_r;
  assign take_a = a_has && (!b_has || ($signed(head_a) < $signed(head_b)));

  // Advance indexes and counts
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    case (state_r)
      slm_pkg::ST_IDLE: begin
        ia_nxt = '0;
        ib_nxt = '0;
        if (we_a) begin
          cnt_a_nxt = cnt_a_r + CW'(1);
        end
        if (we_b) begin
          cnt_b_nxt = cnt_b_r + CW'(1);
        end
        if (accept && (in_req_type == slm_pkg::REQ_MERGE) &&
            (cnt_a_r == '0) && (cnt_b_r == '0)) begin
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
        end
      end
      slm_pkg::ST_EMIT: begin
        if (take_a) begin
          ia_nxt = ia_r + CW'(1);
        end else begin
          ib_nxt = ib_r + CW'(1);
        end
        if ((ia_nxt == cnt_a_r) && (ib_nxt == cnt_b_r)) begin
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
        end
      end
      default: begin
        ia_nxt = '0;
        ib_nxt = '0;
      end
    endcase
  end

  assign done = (ia_nxt == cnt_a_r) && (ib_nxt == cnt_b_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slm_pkg::ST_IDLE: begin
        if (accept && (in_req_type == slm_pkg::REQ_MERGE) &&
            ((cnt_a_r != '0) || (cnt_b_r != '0))) begin
          state_nxt = slm_pkg::ST_EMIT;
        end
      end
      slm_pkg::ST_EMIT: begin
        if (done) begin
          state_nxt = slm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy             = 1'b0;
    out_valid        = 1'b0;
    out_last         = 1'b0;
    out_merged_value = take_a ? head_a : head_b;
    case (state_r)
      slm_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      slm_pkg::ST_EMIT: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        out_last  = done;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slm_pkg::ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ia_r    <= '0;
      ib_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
    end
  end

`ifndef SYNTHESIS
  // The last element of a run returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !busy)
    else $error("busy still high after last element");

  // A merge of a non-empty job starts emitting in the next cycle
  a_merge_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == slm_pkg::REQ_MERGE) &&
     ((cnt_a_r != '0) || (cnt_b_r != '0))) |=> out_valid)
    else $error("merge of stored elements produced no result");

  // Every emitted element comes from a list that still holds one
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (a_has || b_has))
    else $error("result emitted with both lists drained");
`endif

endmodule
`default_nettype wire
